### sv/mbqlpe_pkg.sv
// Package of the multichannel biquad low-pass envelope block.
// Holds the sequencer states, register indexes, reset values and the history row type.
// Depends on nothing; used by multichannel_biquad_lowpass_envelope.
package mbqlpe_pkg;

    // Default number of filter channels that keep history.
    localparam int CHANNELS_DEF = 32;

    // Field widths.
    localparam int CH_W    = 5;
    localparam int RAW_W   = 16;
    localparam int COEF_W  = 32;
    localparam int X_W     = 16;
    localparam int Y_W     = 20;
    localparam int AMP_W   = 16;
    localparam int CFG_I_W = 3;
    localparam int CFG_D_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_I_W-1:0] REG_COEF_B0    = 3'd0;
    localparam logic [CFG_I_W-1:0] REG_COEF_B1    = 3'd1;
    localparam logic [CFG_I_W-1:0] REG_COEF_B2    = 3'd2;
    localparam logic [CFG_I_W-1:0] REG_COEF_A1    = 3'd3;
    localparam logic [CFG_I_W-1:0] REG_COEF_A2    = 3'd4;
    localparam logic [CFG_I_W-1:0] REG_RANGE_LOW  = 3'd5;
    localparam logic [CFG_I_W-1:0] REG_RANGE_HIGH = 3'd6;

    // Register reset values.
    localparam logic signed [COEF_W-1:0] RST_COEF_B0    = 32'sd13555;
    localparam logic signed [COEF_W-1:0] RST_COEF_B1    = 32'sd27110;
    localparam logic signed [COEF_W-1:0] RST_COEF_B2    = 32'sd13555;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1    = -32'sd2136665699;
    localparam logic signed [COEF_W-1:0] RST_COEF_A2    = 32'sd1062978206;
    localparam logic [RAW_W-1:0]         RST_RANGE_LOW  = 16'd200;
    localparam logic [RAW_W-1:0]         RST_RANGE_HIGH = 16'd2000;

    // Normalized value that stands for 1.0.
    localparam logic [X_W-1:0] X_ONE = 16'h8000;

    // Multiply-accumulate taps, one per sequencer step.
    localparam logic [3:0] TAP_B0   = 4'd0;
    localparam logic [3:0] TAP_B1   = 4'd1;
    localparam logic [3:0] TAP_B2   = 4'd2;
    localparam logic [3:0] TAP_A1   = 4'd3;
    localparam logic [3:0] TAP_A2   = 4'd4;
    localparam logic [3:0] TAP_LAST = 4'd5;

    // Last step of the bit-serial divider.
    localparam logic [3:0] DIV_LAST = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_MAC,
        ST_ROUND,
        ST_AMP,
        ST_FIN
    } t_state;

    // One channel's history: newest input, older input, newest output, older output.
    typedef struct packed {
        logic [X_W-1:0]        x1;
        logic [X_W-1:0]        x2;
        logic signed [Y_W-1:0] y1;
        logic signed [Y_W-1:0] y2;
    } t_hist_row;

endpackage

### sv/multichannel_biquad_lowpass_envelope.sv
// Top level of the multichannel biquad low-pass envelope block.
// Normalizer, divider, shared multiplier, history memory and output register.
// Depends on mbqlpe_pkg.
//
// Usage: a request on the input channel (i_in_valid, o_in_stall) carries a channel
// number and a raw pad reading. The reading is mapped from the configured range to
// Q1.15 and clamped, then filtered by that channel's direct-form-I biquad. Each
// request yields one result request on the output channel (o_out_valid, i_out_stall)
// with the channel number, the filtered value in Q4.15 and the amplitude y*y/4.
// Coefficients and range limits are written through the configuration channel, which is
// always ready; writes are to be made only while the block is idle; it does not check this.
//
// Timing: one request at a time goes through a small sequencer. A reading strictly
// inside the range takes the restoring divider (one quotient bit per cycle);
// readings at or outside the range skip it. Five filter taps then share one
// 32x21 multiplier, followed by rounding, the squaring pass on the same multiplier
// and the output load. The result appears in the cycle the block is ready again.
// Reset clears the filter history of all channels at once through per-channel valid
// bits and restores the register defaults. A stalled result is held in the output
// register; the next request is accepted and worked on, and waits only at its
// output load until the register is taken.
module multichannel_biquad_lowpass_envelope #(
    parameter int CHANNELS = mbqlpe_pkg::CHANNELS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [mbqlpe_pkg::CH_W-1:0]            i_in_channel,
    input  logic [mbqlpe_pkg::RAW_W-1:0]           i_in_raw_reading,
    // Output channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mbqlpe_pkg::CH_W-1:0]            o_out_channel,
    output logic signed [mbqlpe_pkg::Y_W-1:0]      o_filtered,
    output logic [mbqlpe_pkg::AMP_W-1:0]           o_amplitude,
    // Configuration write channel.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbqlpe_pkg::CFG_I_W-1:0]         i_cfg_index,
    input  logic [mbqlpe_pkg::CFG_D_W-1:0]         i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACC_W = 57;
    localparam int PROD_W = 53;

    // Configuration registers.
    logic signed [31:0] r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic [15:0]        r_range_low, r_range_high;

    // Sequencer.
    mbqlpe_pkg::t_state r_state, n_state;
    logic [3:0]         r_step;

    // Request under work.
    logic [4:0]         r_ch;
    logic [15:0]        r_raw;
    logic [AW-1:0]      r_addr;
    logic               r_ch_ok;
    logic               r_hist_ok;

    // History memory and per-channel valid bits.
    mbqlpe_pkg::t_hist_row r_hist [CHANNELS];
    logic [CHANNELS-1:0]   r_row_vld;
    mbqlpe_pkg::t_hist_row r_rd_row;
    mbqlpe_pkg::t_hist_row hist;

    // Datapath.
    logic [15:0]               r_x;
    logic [15:0]               r_rem;
    logic [15:0]               r_num;
    logic [15:0]               r_span;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_neg;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [19:0]        r_y;

    // Output register.
    logic               r_out_valid;
    logic [4:0]         r_out_channel;
    logic signed [19:0] r_out_filtered;
    logic [15:0]        r_out_amp;

    logic               in_accept;
    logic               out_free;
    logic [8:0]         ch_ext;
    logic [AW-1:0]      ch_addr;
    logic               ch_ok;
    logic               acc_step;

    logic [15:0]        diff;
    logic [15:0]        span;
    logic [30:0]        num;
    logic [16:0]        trial;
    logic               q_bit;

    logic signed [31:0]       mul_a;
    logic signed [20:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_base;

    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [26:0]       rnd_q;
    logic signed [19:0]       y_sat;

    logic [38:0]        amp_sum;
    logic [21:0]        amp_q;
    logic [15:0]        amp_sat;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Channel decode: channels beyond the store run on zero history and leave it alone.
    assign ch_ext  = {4'b0, i_in_channel};
    assign ch_addr = ch_ext[AW-1:0];
    assign ch_ok   = (ch_ext < 9'(CHANNELS));

    // History of the current request; a channel never written since reset reads as zero.
    assign hist = r_hist_ok ? r_rd_row : '0;

    // Normalizer front end: offset, span and the rounded numerator of the division.
    assign diff = r_raw - r_range_low;
    assign span = r_range_high - r_range_low;
    assign num  = {diff, 15'b0} + {16'b0, span[15:1]};

    // One restoring division step.
    assign trial = {r_rem, r_num[15]};
    assign q_bit = (trial >= {1'b0, r_span});

    // Shared multiplier operand selection. The squaring operands stay selected while
    // the result waits for the output register, so the product register holds y*y.
    always_comb begin
        mul_a = r_coef_b0;
        mul_b = {5'b0, r_x};
        if (r_state == mbqlpe_pkg::ST_AMP || r_state == mbqlpe_pkg::ST_FIN) begin
            mul_a = {{12{r_y[19]}}, r_y};
            mul_b = {r_y[19], r_y};
        end else begin
            case (r_step)
                mbqlpe_pkg::TAP_B0: begin
                    mul_a = r_coef_b0;
                    mul_b = {5'b0, r_x};
                end
                mbqlpe_pkg::TAP_B1: begin
                    mul_a = r_coef_b1;
                    mul_b = {5'b0, hist.x1};
                end
                mbqlpe_pkg::TAP_B2: begin
                    mul_a = r_coef_b2;
                    mul_b = {5'b0, hist.x2};
                end
                mbqlpe_pkg::TAP_A1: begin
                    mul_a = r_coef_a1;
                    mul_b = {hist.y1[19], hist.y1};
                end
                mbqlpe_pkg::TAP_A2: begin
                    mul_a = r_coef_a2;
                    mul_b = {hist.y2[19], hist.y2};
                end
                default: begin
                    mul_a = r_coef_b0;
                    mul_b = {5'b0, r_x};
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Accumulator input: the registered product, negated for the feedback taps.
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_base = (r_step == mbqlpe_pkg::TAP_B1) ? '0 : r_acc;
    assign acc_step = (r_state == mbqlpe_pkg::ST_MAC) && (r_step != mbqlpe_pkg::TAP_B0);

    // Round Q.45 to Q.15 with halves up, then saturate to 20 bits.
    assign rnd_sum = r_acc + 57'sd536870912;
    assign rnd_q   = rnd_sum[56:30];
    always_comb begin
        if (rnd_q > 27'sd524287) begin
            y_sat = 20'sd524287;
        end else if (rnd_q < -27'sd524288) begin
            y_sat = -20'sd524288;
        end else begin
            y_sat = rnd_q[19:0];
        end
    end

    // Amplitude: round y*y from Q.30 to Q.15 with a divide by four, saturate.
    assign amp_sum = r_prod[38:0] + 39'd65536;
    assign amp_q   = amp_sum[38:17];
    assign amp_sat = (|amp_q[21:16]) ? 16'hFFFF : amp_q[15:0];

    // Next state and stall.
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            mbqlpe_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = mbqlpe_pkg::ST_NORM;
                end
            end
            mbqlpe_pkg::ST_NORM: begin
                if (r_raw <= r_range_low || r_raw >= r_range_high) begin
                    n_state = mbqlpe_pkg::ST_MAC;
                end else begin
                    n_state = mbqlpe_pkg::ST_DIV;
                end
            end
            mbqlpe_pkg::ST_DIV: begin
                if (r_step == mbqlpe_pkg::DIV_LAST) begin
                    n_state = mbqlpe_pkg::ST_MAC;
                end
            end
            mbqlpe_pkg::ST_MAC: begin
                if (r_step == mbqlpe_pkg::TAP_LAST) begin
                    n_state = mbqlpe_pkg::ST_ROUND;
                end
            end
            mbqlpe_pkg::ST_ROUND: begin
                n_state = mbqlpe_pkg::ST_AMP;
            end
            mbqlpe_pkg::ST_AMP: begin
                n_state = mbqlpe_pkg::ST_FIN;
            end
            mbqlpe_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = mbqlpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mbqlpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbqlpe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step counter: divider bits and multiplier taps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state != n_state) begin
            r_step <= '0;
        end else if (r_state == mbqlpe_pkg::ST_DIV || r_state == mbqlpe_pkg::ST_MAC) begin
            r_step <= r_step + 4'd1;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0    <= mbqlpe_pkg::RST_COEF_B0;
            r_coef_b1    <= mbqlpe_pkg::RST_COEF_B1;
            r_coef_b2    <= mbqlpe_pkg::RST_COEF_B2;
            r_coef_a1    <= mbqlpe_pkg::RST_COEF_A1;
            r_coef_a2    <= mbqlpe_pkg::RST_COEF_A2;
            r_range_low  <= mbqlpe_pkg::RST_RANGE_LOW;
            r_range_high <= mbqlpe_pkg::RST_RANGE_HIGH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mbqlpe_pkg::REG_COEF_B0:    r_coef_b0    <= i_cfg_data;
                mbqlpe_pkg::REG_COEF_B1:    r_coef_b1    <= i_cfg_data;
                mbqlpe_pkg::REG_COEF_B2:    r_coef_b2    <= i_cfg_data;
                mbqlpe_pkg::REG_COEF_A1:    r_coef_a1    <= i_cfg_data;
                mbqlpe_pkg::REG_COEF_A2:    r_coef_a2    <= i_cfg_data;
                mbqlpe_pkg::REG_RANGE_LOW:  r_range_low  <= i_cfg_data[15:0];
                mbqlpe_pkg::REG_RANGE_HIGH: r_range_high <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture and history read; the row arrives in the cycle after acceptance.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch      <= i_in_channel;
            r_raw     <= i_in_raw_reading;
            r_addr    <= ch_addr;
            r_ch_ok   <= ch_ok;
            r_hist_ok <= ch_ok ? r_row_vld[ch_addr] : 1'b0;
            r_rd_row  <= r_hist[ch_addr];
        end
    end

    // History write once the output sample is known.
    always_ff @(posedge i_clk) begin
        if (r_state == mbqlpe_pkg::ST_ROUND && r_ch_ok) begin
            r_hist[r_addr] <= '{x1: r_x, x2: hist.x1, y1: y_sat, y2: hist.y1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (r_state == mbqlpe_pkg::ST_ROUND && r_ch_ok) begin
            r_row_vld[r_addr] <= 1'b1;
        end
    end

    // Normalizer and divider.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mbqlpe_pkg::ST_NORM: begin
                if (r_raw <= r_range_low) begin
                    r_x <= '0;
                end else if (r_raw >= r_range_high) begin
                    r_x <= mbqlpe_pkg::X_ONE;
                end else begin
                    r_x <= '0;
                end
                r_span <= span;
                r_rem  <= {1'b0, num[30:16]};
                r_num  <= num[15:0];
            end
            mbqlpe_pkg::ST_DIV: begin
                r_rem <= q_bit ? 16'(trial - {1'b0, r_span}) : trial[15:0];
                r_num <= {r_num[14:0], 1'b0};
                r_x   <= {r_x[14:0], q_bit};
            end
            default: begin
            end
        endcase
    end

    // Shared multiplier with its product register, and the accumulator.
    always_ff @(posedge i_clk) begin
        r_prod     <= mul_p;
        r_prod_neg <= (r_step == mbqlpe_pkg::TAP_A1) || (r_step == mbqlpe_pkg::TAP_A2);
        if (acc_step) begin
            r_acc <= r_prod_neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
        end
        if (r_state == mbqlpe_pkg::ST_ROUND) begin
            r_y <= y_sat;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mbqlpe_pkg::ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mbqlpe_pkg::ST_FIN && out_free) begin
            r_out_channel  <= r_ch;
            r_out_filtered <= r_y;
            r_out_amp      <= amp_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_filtered    = r_out_filtered;
    assign o_amplitude   = r_out_amp;

endmodule

### tb/multichannel_biquad_lowpass_envelope_checker.sv
// Checker for the multichannel biquad low-pass envelope block.
// Watches the input, output and configuration channels, predicts each result
// and compares it field by field. Depends on mbqlpe_pkg.
module multichannel_biquad_lowpass_envelope_checker
    import mbqlpe_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [CH_W-1:0]         i_in_channel,
    input  logic [RAW_W-1:0]        i_in_raw_reading,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [CH_W-1:0]         i_out_channel,
    input  logic signed [Y_W-1:0]   i_filtered,
    input  logic [AMP_W-1:0]        i_amplitude,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_I_W-1:0]      i_cfg_index,
    input  logic [CFG_D_W-1:0]      i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_checked
);

    localparam longint FILT_MAX = (longint'(1) << (Y_W - 1)) - 1;
    localparam longint FILT_MIN = -(longint'(1) << (Y_W - 1));
    localparam longint AMP_MAX  = (longint'(1) << AMP_W) - 1;

    typedef struct packed {
        logic [CH_W-1:0]        channel;
        logic signed [Y_W-1:0]  filtered;
        logic [AMP_W-1:0]       amplitude;
    } t_pad_result;

    // Shadow copy of the registers and of the per-channel filter history.
    logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic [RAW_W-1:0]         range_lo, range_hi;
    logic [X_W-1:0]           x_hist1 [CHANNELS];
    logic [X_W-1:0]           x_hist2 [CHANNELS];
    logic signed [Y_W-1:0]    y_hist1 [CHANNELS];
    logic signed [Y_W-1:0]    y_hist2 [CHANNELS];

    t_pad_result expected_results [$];
    int          fails;
    int          checked;

    // Maps a raw reading onto Q1.15, rounding the quotient to nearest.
    function automatic logic [X_W-1:0] normalize_reading(logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0] span;
        longint           num;
        if (raw <= range_lo) return '0;
        if (raw >= range_hi) return X_ONE;
        span = range_hi - range_lo;
        num  = (longint'(raw - range_lo) << 15) + longint'(span >> 1);
        return X_W'(num / longint'(span));
    endfunction

    // Runs one reading through the channel's biquad and advances its history.
    function automatic t_pad_result filter_reading(logic [CH_W-1:0] ch,
                                                   logic [RAW_W-1:0] raw);
        t_pad_result           res;
        logic [X_W-1:0]        x, px1, px2;
        logic signed [Y_W-1:0] py1, py2;
        logic                  known;
        longint                acc, y, amp;
        x     = normalize_reading(raw);
        known = int'(ch) < CHANNELS;
        px1   = '0;
        px2   = '0;
        py1   = '0;
        py2   = '0;
        if (known) begin
            px1 = x_hist1[ch];
            px2 = x_hist2[ch];
            py1 = y_hist1[ch];
            py2 = y_hist2[ch];
        end
        acc = longint'(coef_b0) * longint'(x) + longint'(coef_b1) * longint'(px1)
            + longint'(coef_b2) * longint'(px2) - longint'(coef_a1) * longint'(py1)
            - longint'(coef_a2) * longint'(py2);
        y = (acc + (longint'(1) << 29)) >>> 30;
        if (y > FILT_MAX) begin
            y = FILT_MAX;
        end else if (y < FILT_MIN) begin
            y = FILT_MIN;
        end
        if (known) begin
            x_hist2[ch] = px1;
            x_hist1[ch] = x;
            y_hist2[ch] = py1;
            y_hist1[ch] = Y_W'(y);
        end
        amp = (y * y + (longint'(1) << 16)) >>> 17;
        if (amp > AMP_MAX) amp = AMP_MAX;
        res.channel   = ch;
        res.filtered  = Y_W'(y);
        res.amplitude = AMP_W'(amp);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pad_result want;
        if (!i_rst_n) begin
            coef_b0  = RST_COEF_B0;
            coef_b1  = RST_COEF_B1;
            coef_b2  = RST_COEF_B2;
            coef_a1  = RST_COEF_A1;
            coef_a2  = RST_COEF_A2;
            range_lo = RST_RANGE_LOW;
            range_hi = RST_RANGE_HIGH;
            for (int i = 0; i < CHANNELS; i++) begin
                x_hist1[i] = '0;
                x_hist2[i] = '0;
                y_hist1[i] = '0;
                y_hist2[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_B0:    coef_b0 = i_cfg_data;
                    REG_COEF_B1:    coef_b1 = i_cfg_data;
                    REG_COEF_B2:    coef_b2 = i_cfg_data;
                    REG_COEF_A1:    coef_a1 = i_cfg_data;
                    REG_COEF_A2:    coef_a2 = i_cfg_data;
                    REG_RANGE_LOW:  range_lo = i_cfg_data[RAW_W-1:0];
                    REG_RANGE_HIGH: range_hi = i_cfg_data[RAW_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(filter_reading(i_in_channel, i_in_raw_reading));
            end
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result: expected none, actual channel %0d",
                             $time, i_out_channel);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_channel !== want.channel) begin
                        fails++;
                        $display("%0t out_channel: expected %0d, actual %0d",
                                 $time, want.channel, i_out_channel);
                    end
                    if (i_filtered !== want.filtered) begin
                        fails++;
                        $display("%0t filtered (channel %0d): expected %0d, actual %0d",
                                 $time, want.channel, want.filtered, i_filtered);
                    end
                    if (i_amplitude !== want.amplitude) begin
                        fails++;
                        $display("%0t amplitude (channel %0d): expected %0d, actual %0d",
                                 $time, want.channel, want.amplitude, i_amplitude);
                    end
                end
            end
        end
        o_fail_count      <= fails;
        o_pending         <= expected_results.size();
        o_results_checked <= checked;
    end

endmodule

### tb/multichannel_biquad_lowpass_envelope_tb.sv
// Top of the testbench for the multichannel biquad low-pass envelope block.
// Drives readings and register writes, idles both sides and gives the verdict;
// the checking is done by multichannel_biquad_lowpass_envelope_checker.
module multichannel_biquad_lowpass_envelope_tb;
    import mbqlpe_pkg::*;

    // Readings per filter setting in the random part.
    localparam int RAND_PER_SETTING = 285;
    // Cycles the receiver refuses results once, so that the block backs up.
    localparam int LONG_HOLD = 400;
    // Quiet cycles after the last result before a register write or the end.
    // This covers any leftover work, also that of a request with division.
    localparam int DRAIN_CYCLES = 40;
    // Overall cycle limit, far beyond what a correct run needs.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_I_W-1:0] REG_UNUSED = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CH_W-1:0]       i_in_channel = '0;
    logic [RAW_W-1:0]      i_in_raw_reading = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CH_W-1:0]       o_out_channel;
    logic signed [Y_W-1:0] o_filtered;
    logic [AMP_W-1:0]      o_amplitude;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_I_W-1:0]    i_cfg_index = '0;
    logic [CFG_D_W-1:0]    i_cfg_data = '0;

    int fail_count;
    int pending_results;
    int results_checked;

    // Stimulus bookkeeping: our copy of the range limits steers the raw values
    // toward the interesting part of the transfer curve.
    logic [RAW_W-1:0] range_lo_cfg = RST_RANGE_LOW;
    logic [RAW_W-1:0] range_hi_cfg = RST_RANGE_HIGH;
    int               readings_sent = 0;
    int               settings_used = 1;
    int               burst_left = 8;
    int               cycle_count = 0;
    logic             hold_request = 1'b0;

    multichannel_biquad_lowpass_envelope u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_channel     (i_in_channel),
        .i_in_raw_reading (i_in_raw_reading),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_channel    (o_out_channel),
        .o_filtered       (o_filtered),
        .o_amplitude      (o_amplitude),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    multichannel_biquad_lowpass_envelope_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_in_channel      (i_in_channel),
        .i_in_raw_reading  (i_in_raw_reading),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_out_channel     (o_out_channel),
        .i_filtered        (o_filtered),
        .i_amplitude       (o_amplitude),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results),
        .o_results_checked (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offers one reading and holds it until the block takes the request. The
    // sender works in bursts: when a burst runs out, valid may drop for a random
    // gap, and sometimes the next burst follows at once.
    task automatic send_reading(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw);
        int gap;
        i_in_valid       <= 1'b1;
        i_in_channel     <= ch;
        i_in_raw_reading <= raw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        readings_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 32);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Random readings. Most raw values fall in or just around the configured
    // range, where the division and the clamp edges live; the rest are uniform
    // or pinned to the extremes and the limits. Half of the requests go to a
    // few channels so that their history builds up and the filter settles.
    task automatic run_readings(input int count);
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        int               w_lo, w_hi;
        w_lo = ((range_lo_cfg < range_hi_cfg) ? int'(range_lo_cfg) : int'(range_hi_cfg)) - 4;
        w_hi = ((range_lo_cfg > range_hi_cfg) ? int'(range_lo_cfg) : int'(range_hi_cfg)) + 4;
        if (w_lo < 0) w_lo = 0;
        if (w_hi > 65535) w_hi = 65535;
        repeat (count) begin
            ch = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 3)) : CH_W'($urandom());
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: raw = RAW_W'($urandom_range(w_lo, w_hi));
                6, 7, 8:          raw = RAW_W'($urandom());
                default: begin
                    case ($urandom_range(0, 3))
                        0:       raw = '0;
                        1:       raw = '1;
                        2:       raw = range_lo_cfg;
                        default: raw = range_hi_cfg;
                    endcase
                end
            endcase
            send_reading(ch, raw);
        end
    endtask

    // Stops offering readings and waits until every predicted result has been
    // taken, then lets the block finish any work still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_I_W-1:0] idx,
                                  input logic [CFG_D_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Writes all seven registers back to back. With poke_unused set, a write to
    // the index with no register follows, with data that would break the
    // filter if the block took it.
    task automatic apply_setting(input logic [31:0] b0, input logic [31:0] b1,
                                 input logic [31:0] b2, input logic [31:0] a1,
                                 input logic [31:0] a2, input logic [RAW_W-1:0] lo,
                                 input logic [RAW_W-1:0] hi, input logic poke_unused);
        write_register(REG_COEF_B0, b0);
        write_register(REG_COEF_B1, b1);
        write_register(REG_COEF_B2, b2);
        write_register(REG_COEF_A1, a1);
        write_register(REG_COEF_A2, a2);
        write_register(REG_RANGE_LOW, CFG_D_W'(lo));
        write_register(REG_RANGE_HIGH, CFG_D_W'(hi));
        if (poke_unused) write_register(REG_UNUSED, 32'h8000_0001);
        i_cfg_valid  <= 1'b0;
        range_lo_cfg = lo;
        range_hi_cfg = hi;
        settings_used++;
    endtask

    // The receiver changes its manner from one stretch to the next: never stalling,
    // stalling now and then, stalling most of the time, or alternating. Once,
    // on request from the stimulus, it refuses results for a long stretch while
    // readings keep coming, so the output register fills and the input stalls.
    initial begin : receiver
        int   mode;
        int   seg_len;
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(16, 160);
            repeat (seg_len) begin
                @(posedge i_clk);
                if (hold_request && !hold_done) begin
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("multichannel_biquad_lowpass_envelope: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]      rnd_coef [5];
        logic [RAW_W-1:0] rnd_lo, rnd_hi;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed readings under the reset defaults (range 200..2000): both
        // clamp sides, the limits and their neighbors, a midpoint, the largest
        // reading repeated on the top channel so its history grows, and
        // alternating bit patterns on channels 1 and 30.
        send_reading(5'd0, 16'd0);
        send_reading(5'd0, 16'hFFFF);
        send_reading(5'd0, 16'd199);
        send_reading(5'd0, 16'd200);
        send_reading(5'd0, 16'd201);
        send_reading(5'd0, 16'd1100);
        send_reading(5'd0, 16'd1999);
        send_reading(5'd0, 16'd2000);
        send_reading(5'd0, 16'd2001);
        send_reading(5'd31, 16'hFFFF);
        send_reading(5'd31, 16'hFFFF);
        send_reading(5'd31, 16'hFFFF);
        send_reading(5'd31, 16'hFFFF);
        send_reading(5'd31, 16'd0);
        send_reading(5'd1, 16'hAAAA);
        send_reading(5'd30, 16'h5555);
        send_reading(5'd16, 16'd1101);
        send_reading(5'd15, 16'hFFFE);
        send_reading(5'd31, 16'd1999);
        send_reading(5'd0, 16'd0);
        run_readings(RAND_PER_SETTING);

        // Pass-through filter over the full raw span; the long hold-off of the
        // receiver happens in this stretch.
        wait_idle();
        apply_setting(32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 1'b0);
        hold_request <= 1'b1;
        run_readings(RAND_PER_SETTING);

        // Largest coefficients with positive feedback: the output runs into the
        // upper limit. The range is empty, so readings only clamp.
        wait_idle();
        apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 16'd1000, 16'd1000, 1'b0);
        run_readings(RAND_PER_SETTING);

        // Most negative feedforward weights drive the output to the lower limit;
        // the range is inverted.
        wait_idle();
        apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 16'd60000, 16'd100, 1'b0);
        run_readings(RAND_PER_SETTING);

        // Arbitrary coefficients over a three-count range, where rounding of the
        // quotient decides every interior value.
        wait_idle();
        for (int i = 0; i < 5; i++) rnd_coef[i] = $urandom();
        apply_setting(rnd_coef[0], rnd_coef[1], rnd_coef[2], rnd_coef[3], rnd_coef[4],
                      16'd100, 16'd103, 1'b0);
        run_readings(RAND_PER_SETTING);

        // Moderate coefficients within about +-0.25 and a random proper range.
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            rnd_coef[i] = $urandom();
            rnd_coef[i] = {{3{rnd_coef[i][28]}}, rnd_coef[i][28:0]};
        end
        rnd_lo = RAW_W'($urandom_range(0, 30000));
        rnd_hi = RAW_W'($urandom_range(int'(rnd_lo) + 1, 65535));
        apply_setting(rnd_coef[0], rnd_coef[1], rnd_coef[2], rnd_coef[3], rnd_coef[4],
                      rnd_lo, rnd_hi, 1'b0);
        run_readings(RAND_PER_SETTING);

        // Back to the reset values written explicitly, followed by a write to
        // the unused index that must leave them alone.
        wait_idle();
        apply_setting(RST_COEF_B0, RST_COEF_B1, RST_COEF_B2, RST_COEF_A1, RST_COEF_A2,
                      RST_RANGE_LOW, RST_RANGE_HIGH, 1'b1);
        run_readings(RAND_PER_SETTING);

        wait_idle();
        $display("Covered %0d readings under %0d filter settings, including empty, inverted",
                 readings_sent, settings_used);
        $display("and tiny ranges, output saturation and a %0d-cycle output hold-off; %0d checked.",
                 LONG_HOLD, results_checked);
        if (fail_count == 0) begin
            $display("multichannel_biquad_lowpass_envelope: match");
        end else begin
            $display("multichannel_biquad_lowpass_envelope: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
sv/mbqlpe_pkg.sv
sv/multichannel_biquad_lowpass_envelope.sv
tb/multichannel_biquad_lowpass_envelope_checker.sv
tb/multichannel_biquad_lowpass_envelope_tb.sv
